// ===== design/jtss_pkg.sv =====
// Package for the joystick / tilt servo smoother.
// Holds the item types, the sequencer states, the arithmetic constants and the
// arctangent table. It depends on nothing.
package jtss_pkg;

    // Servo range and filter format.
    localparam int ANGLE_TOP        = 180;
    localparam int FILTER_FRAC_BITS = 8;
    localparam int FILT_W           = 8 + FILTER_FRAC_BITS;
    localparam int WEIGHT_ONE       = 256;
    localparam int WEIGHT_FRAC      = 8;

    // Square root over (ay*ay + az*az) * 2^16, at most 37 bits.
    localparam int ROOT_W       = 40;
    localparam int ROOT_TOP_BIT = 38;
    localparam int SQRT_ITERS   = ROOT_TOP_BIT / 2 + 1;

    // Vectoring rotation datapath.
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORD_W       = 24;
    localparam int Z_W          = 25;
    localparam int Z_FRAC       = 16;
    localparam int CNT_W        = 5;

    // Division by 180 is done as a shift by two and a division by 45.
    localparam int DIV45_MUL   = 1457;
    localparam int DIV45_SHIFT = 16;
    localparam int DIV45       = 45;

    // Arctangent of 2^-i in degrees, Q6.16, rounded to nearest.
    localparam logic [21:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    // Configuration register indexes.
    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_DEADBAND = 2'd2;
    localparam logic [1:0] CFG_WEIGHT   = 2'd3;

    typedef struct packed {
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [9:0] accel_x;
        logic [9:0] accel_y;
        logic [9:0] accel_z;
        logic       button_c;
        logic       button_z;
    } t_in_item;

    typedef struct packed {
        logic [7:0] angle_one;
        logic [7:0] angle_two;
        logic [7:0] angle_three;
        logic       magnet_on;
    } t_out_item;

    // A classified sample as it waits between the front and the back.
    typedef struct packed {
        logic       tilt;
        logic [7:0] target_one;
        logic [7:0] target_two;
        logic [9:0] accel_x;
        logic [9:0] accel_y;
        logic [9:0] accel_z;
        logic       button_z;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_CORDIC,
        S_SCALE,
        S_RECIP,
        S_FIX,
        S_FILTER
    } t_back_state;

endpackage

// ===== design/jtss_front.sv =====
// Front of the smoother: classifies a sample and works out the stick targets.
// Uses the item and job types from jtss_pkg.
module jtss_front (
    input  jtss_pkg::t_in_item i_item,
    input  logic [7:0]         i_center_x,
    input  logic [7:0]         i_center_y,
    input  logic [7:0]         i_deadband,
    output jtss_pkg::t_job     o_job
);
    import jtss_pkg::*;

    // Snap to centre inside the deadband, then scale v*ANGLE_TOP/255.
    // x/255 equals (x + (x >> 8) + 1) >> 8 for every x below 65280.
    function automatic logic [7:0] stick_target(input logic [7:0] v, input logic [7:0] c,
                                                input logic [7:0] db);
        logic [7:0]  offset;
        logic [7:0]  val;
        logic [15:0] prod;
        logic [16:0] sum;
        offset = (v >= c) ? (v - c) : (c - v);
        val    = (offset < db) ? c : v;
        prod   = val * 16'(ANGLE_TOP);
        sum    = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    always_comb begin
        o_job.tilt       = i_item.button_c;
        o_job.target_one = stick_target(i_item.joy_x, i_center_x, i_deadband);
        o_job.target_two = stick_target(i_item.joy_y, i_center_y, i_deadband);
        o_job.accel_x    = i_item.accel_x;
        o_job.accel_y    = i_item.accel_y;
        o_job.accel_z    = i_item.accel_z;
        o_job.button_z   = i_item.button_z;
    end

endmodule

// ===== design/jtss_queue.sv =====
// Two-entry job queue between the front and the back of the smoother.
// Uses the job type from jtss_pkg.
module jtss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jtss_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output jtss_pkg::t_job o_job,
    output logic           o_empty
);
    import jtss_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// ===== design/jtss_back.sv =====
// Back of the smoother: pitch by square root and rotation, then the three filters.
// Uses the job, result, state types and constants from jtss_pkg.
module jtss_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8:0]          i_weight,
    input  jtss_pkg::t_job      i_job,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    output jtss_pkg::t_out_item o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import jtss_pkg::*;

    localparam int DIFF_W = FILT_W + 2;
    localparam int PROD_W = DIFF_W + 10;
    localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(90 << FILTER_FRAC_BITS);

    t_back_state         r_state, n_state;
    logic                r_res_valid, n_res_valid;
    t_out_item           r_res, n_res;
    logic [FILT_W-1:0]   r_f1, n_f1, r_f2, n_f2, r_f3, n_f3;
    t_job                r_job, n_job;
    logic [ROOT_W-1:0]   r_rem, n_rem, r_root, n_root, r_bit, n_bit;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic signed [CORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [Z_W-1:0]    r_cz, n_cz;
    logic [7:0]          r_p, n_p;
    logic [13:0]         r_sx, n_sx;
    logic [7:0]          r_est, n_est;
    logic [7:0]          r_t1, n_t1, r_t2, n_t2, r_t3, n_t3;

    logic [19:0]         sq_y, sq_z;
    logic [ROOT_W-1:0]   trial;
    logic signed [CORD_W-1:0] sh_x, sh_y;
    logic signed [Z_W-1:0]    atan_z, z_abs;
    logic [8:0]          deg;
    logic [15:0]         p_scaled;
    logic [24:0]         recip;
    logic [13:0]         back_mul;
    logic [7:0]          fixed;
    logic [8:0]          w_eff;

    // One filter step: f += floor(w * (t*2^FRAC - f) / 256), saturated.
    function automatic logic [FILT_W-1:0] filt_next(input logic [FILT_W-1:0] f,
                                                    input logic [7:0] t,
                                                    input logic [8:0] w);
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        diff = signed'({2'b00, t, {FILTER_FRAC_BITS{1'b0}}}) - signed'({2'b00, f});
        prod = signed'({1'b0, w}) * diff;
        sum  = signed'(PROD_W'(f)) + (prod >>> WEIGHT_FRAC);
        if (sum < 0) begin
            return '0;
        end else if (sum > signed'(PROD_W'({FILT_W{1'b1}}))) begin
            return '1;
        end
        return sum[FILT_W-1:0];
    endfunction

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    assign o_result  = r_res;
    assign o_empty   = !r_res_valid;
    assign w_eff     = (i_weight > 9'(WEIGHT_ONE)) ? 9'(WEIGHT_ONE) : i_weight;

    // Sequencer: next state and datapath values.
    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && !i_pop;
        n_res       = r_res;
        n_f1        = r_f1;
        n_f2        = r_f2;
        n_f3        = r_f3;
        n_job       = r_job;
        n_rem       = r_rem;
        n_root      = r_root;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_p         = r_p;
        n_sx        = r_sx;
        n_est       = r_est;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_t3        = r_t3;

        sq_y     = r_job.accel_y * r_job.accel_y;
        sq_z     = r_job.accel_z * r_job.accel_z;
        trial    = r_root + r_bit;
        sh_x     = r_cx >>> r_cnt;
        sh_y     = r_cy >>> r_cnt;
        atan_z   = signed'(Z_W'(ATAN_TAB[r_cnt]));
        z_abs    = '0;
        deg      = '0;
        p_scaled = r_p * 16'(ANGLE_TOP);
        recip    = r_sx * 25'(DIV45_MUL);
        back_mul = r_est * 14'(DIV45);
        fixed    = (back_mul > r_sx) ? (r_est - 8'd1) : r_est;

        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_job = i_job;
                    n_t1  = r_f1[FILT_W-1:FILTER_FRAC_BITS];
                    n_t2  = r_f2[FILT_W-1:FILTER_FRAC_BITS];
                    n_t3  = r_f3[FILT_W-1:FILTER_FRAC_BITS];
                    if (!i_job.tilt) begin
                        n_t1    = i_job.target_one;
                        n_t2    = i_job.target_two;
                        n_state = S_FILTER;
                    end else if (i_job.accel_x == '0) begin
                        // No forward tilt: the pitch is level.
                        n_p     = 8'd90;
                        n_state = S_SCALE;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_SQUARE: begin
                n_rem   = ROOT_W'({1'b0, sq_y} + {1'b0, sq_z}) << 16;
                n_root  = '0;
                n_bit   = ROOT_W'(1) << ROOT_TOP_BIT;
                n_cnt   = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                // One bit of the integer square root per cycle.
                if (r_rem >= trial) begin
                    n_rem  = r_rem - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_ITERS - 1)) begin
                    n_cnt = '0;
                    if (n_root == '0) begin
                        // Stick-free vertical: pitch is straight down.
                        n_p     = 8'd0;
                        n_state = S_SCALE;
                    end else begin
                        n_cx    = signed'(n_root[CORD_W-1:0]);
                        n_cy    = -signed'(CORD_W'({r_job.accel_x, 8'd0}));
                        n_cz    = '0;
                        n_state = S_CORDIC;
                    end
                end
            end
            S_CORDIC: begin
                // One vectoring rotation per cycle toward the x axis.
                if (r_cy > 0) begin
                    n_cx = r_cx + sh_y;
                    n_cy = r_cy - sh_x;
                    n_cz = r_cz + atan_z;
                end else begin
                    n_cx = r_cx - sh_y;
                    n_cy = r_cy + sh_x;
                    n_cz = r_cz - atan_z;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    // Truncate toward zero, clamp to +-90, shift onto 0..180.
                    z_abs = (n_cz < 0) ? -n_cz : n_cz;
                    deg   = z_abs[Z_W-1:Z_FRAC];
                    if (deg > 9'd90) begin
                        deg = 9'd90;
                    end
                    n_p     = (n_cz < 0) ? (8'd90 - deg[7:0]) : (8'd90 + deg[7:0]);
                    n_cnt   = '0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_sx    = p_scaled[15:2];
                n_state = S_RECIP;
            end
            S_RECIP: begin
                n_est   = recip[DIV45_SHIFT+7:DIV45_SHIFT];
                n_state = S_FIX;
            end
            S_FIX: begin
                // The reciprocal estimate is at most one too high.
                n_t3    = (fixed > 8'(ANGLE_TOP)) ? 8'(ANGLE_TOP) : fixed;
                n_state = S_FILTER;
            end
            S_FILTER: begin
                // Update the filters only once the result slot is free.
                if (!r_res_valid || i_pop) begin
                    n_f1              = filt_next(r_f1, r_t1, w_eff);
                    n_f2              = filt_next(r_f2, r_t2, w_eff);
                    n_f3              = filt_next(r_f3, r_t3, w_eff);
                    n_res.angle_one   = n_f1[FILT_W-1:FILTER_FRAC_BITS];
                    n_res.angle_two   = n_f2[FILT_W-1:FILTER_FRAC_BITS];
                    n_res.angle_three = n_f3[FILT_W-1:FILTER_FRAC_BITS];
                    n_res.magnet_on   = r_job.button_z;
                    n_res_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, result flag and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_f1        <= FILT_RESET;
            r_f2        <= FILT_RESET;
            r_f3        <= FILT_RESET;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_f1        <= n_f1;
            r_f2        <= n_f2;
            r_f3        <= n_f3;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_job  <= n_job;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_p    <= n_p;
        r_sx   <= n_sx;
        r_est  <= n_est;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_t3   <= n_t3;
    end

endmodule

// ===== design/joystick_tilt_servo_smoother.sv =====
// Top level of the joystick / tilt servo smoother.
// Instantiates jtss_front, jtss_queue and jtss_back; types come from jtss_pkg.
//
// Each controller sample pushed in gives exactly one result of three smoothed
// servo angles and the magnet bit, in order. The front classifies a sample and
// computes the stick targets in the cycle it is accepted, and a two-entry queue
// holds it until the back sequencer is free. In the back a joystick sample goes
// straight to filtering; a tilt sample first squares the readings, then runs the
// bit-per-cycle square root, the rotation, and the scaling and filtering, all on
// one shared sequencer. A tilt sample with no forward component skips the root
// and the rotation. The result waits in an output register, so the back goes on
// with the next queued sample, up to its filter step, while it is not taken.
// Configuration writes are always ready; the user must make them only while the
// block is idle, which the block itself does not enforce.
module joystick_tilt_servo_smoother (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  jtss_pkg::t_in_item  i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output jtss_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);
    import jtss_pkg::*;

    logic [7:0] r_center_x;
    logic [7:0] r_center_y;
    logic [7:0] r_deadband;
    logic [8:0] r_weight;
    t_job       front_job;
    t_job       queue_job;
    logic       queue_empty;
    logic       queue_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= 8'd128;
            r_center_y <= 8'd128;
            r_deadband <= 8'd10;
            r_weight   <= 9'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data[7:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[7:0];
                CFG_DEADBAND: r_deadband <= i_cfg_data[7:0];
                CFG_WEIGHT:   r_weight   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    jtss_front u_front (
        .i_item     (i_item),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_deadband (r_deadband),
        .o_job      (front_job)
    );

    jtss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    jtss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_weight    (r_weight),
        .i_job       (queue_job),
        .i_job_empty (queue_empty),
        .o_job_pop   (queue_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== design/jtss_checker.sv =====
// Port-level checks for the joystick / tilt servo smoother, bound to its top.
// Uses the result type and ANGLE_TOP from jtss_pkg.
module jtss_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input jtss_pkg::t_out_item o_result,
    input logic                o_cfg_ready
);
    import jtss_pkg::*;

    // Nothing is waiting right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // The input queue fills only through an accepted item.
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue became full without an item");

    // Every angle shown lies in the servo range.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.angle_one <= 8'(ANGLE_TOP)) &&
                   (o_result.angle_two <= 8'(ANGLE_TOP)) &&
                   (o_result.angle_three <= 8'(ANGLE_TOP)))
        else $error("angle out of servo range");

    // A waiting result stays put until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

    // The configuration channel never stalls outside reset.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind joystick_tilt_servo_smoother jtss_checker u_jtss_checker (.*);

// ===== tb/joystick_tilt_servo_smoother_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for joystick_tilt_servo_smoother.
// Predicts every result from its own model of the stick scaling, pitch rotation
// and smoothing filters, and checks the block's results in order. Uses jtss_pkg.
module joystick_tilt_servo_smoother_tb;
    import jtss_pkg::*;

    localparam longint SERVO_TOP    = 180;
    localparam longint FRAC         = 8;
    localparam longint FILTER_MAX   = 65535;
    localparam int     ROT_STEPS    = 16;
    localparam int     DRAIN_CYCLES = 64;

    // Arctangent of 2^-i in degrees, Q16.16.
    localparam longint ATAN_DEG [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    t_in_item   sample_in = '0;
    logic       full;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  angles_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    // Settings and filter state as the predictor sees them.
    longint ctr_x = 128;
    longint ctr_y = 128;
    longint dead_zone = 10;
    longint weight = 64;
    longint filt_one = 23040;
    longint filt_two = 23040;
    longint filt_three = 23040;

    t_out_item pending_angles[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 20;
    int        hold_off_cycles = 0;

    joystick_tilt_servo_smoother dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (sample_in),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (angles_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bit-by-bit integer square root, floor of the true root.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        int b;
        root = 0;
        for (b = 24; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Pitch in whole degrees, truncated toward zero, from the vectoring rotation.
    function automatic longint tilt_pitch(longint ax, longint ay, longint az);
        longint unsigned mag2;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint deg;
        int i;
        if (ax == 0) begin
            return 0;
        end
        mag2 = (ay * ay + az * az) << 16;
        x = longint'(int_sqrt(mag2));
        y = -(ax <<< 8);
        if (x == 0) begin
            return -90;
        end
        z = 0;
        for (i = 0; i < ROT_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_DEG[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_DEG[i];
            end
            x = nx;
        end
        deg = (z < 0) ? -((-z) >>> 16) : (z >>> 16);
        if (deg < -90) deg = -90;
        if (deg > 90) deg = 90;
        return deg;
    endfunction

    // Stick axis to servo target, snapped to the centre inside the deadband.
    function automatic longint stick_angle(longint v, longint ctr);
        longint offset;
        offset = (v > ctr) ? v - ctr : ctr - v;
        if (offset < dead_zone) begin
            v = ctr;
        end
        return v * SERVO_TOP / 255;
    endfunction

    // One exponential smoother update with floor shift and saturation.
    function automatic longint smooth_step(longint f, longint tgt);
        longint w;
        w = (weight > 256) ? 256 : weight;
        f = f + ((w * ((tgt <<< FRAC) - f)) >>> 8);
        if (f < 0) f = 0;
        if (f > FILTER_MAX) f = FILTER_MAX;
        return f;
    endfunction

    // Advance the filters by one accepted sample and queue the expected angles.
    function automatic void predict_angles(t_in_item s);
        longint    t1;
        longint    t2;
        longint    t3;
        t_out_item want;
        t1 = filt_one >>> FRAC;
        t2 = filt_two >>> FRAC;
        t3 = filt_three >>> FRAC;
        if (s.button_c) begin
            t3 = (tilt_pitch(longint'(s.accel_x), longint'(s.accel_y),
                             longint'(s.accel_z)) + 90) * SERVO_TOP / 180;
            if (t3 > SERVO_TOP) t3 = SERVO_TOP;
        end else begin
            t1 = stick_angle(longint'(s.joy_x), ctr_x);
            t2 = stick_angle(longint'(s.joy_y), ctr_y);
        end
        filt_one = smooth_step(filt_one, t1);
        filt_two = smooth_step(filt_two, t2);
        filt_three = smooth_step(filt_three, t3);
        want.angle_one = 8'(filt_one >>> FRAC);
        want.angle_two = 8'(filt_two >>> FRAC);
        want.angle_three = 8'(filt_three >>> FRAC);
        want.magnet_on = s.button_z;
        pending_angles.push_back(want);
    endfunction

    function automatic void apply_setting(logic [1:0] idx, logic [8:0] val);
        case (idx)
            CFG_CENTER_X: ctr_x = longint'(val[7:0]);
            CFG_CENTER_Y: ctr_y = longint'(val[7:0]);
            CFG_DEADBAND: dead_zone = longint'(val[7:0]);
            CFG_WEIGHT:   weight = longint'(val);
            default: ;
        endcase
    endfunction

    function automatic void report_field(string field, int want, int got);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    // Compare one result item against the oldest expectation.
    function automatic void check_angles(t_out_item got);
        t_out_item want;
        if (pending_angles.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual %0d %0d %0d %0d",
                     $time, got.angle_one, got.angle_two, got.angle_three,
                     got.magnet_on);
            return;
        end
        want = pending_angles.pop_front();
        if (got.angle_one !== want.angle_one)
            report_field("angle_one", int'(want.angle_one), int'(got.angle_one));
        if (got.angle_two !== want.angle_two)
            report_field("angle_two", int'(want.angle_two), int'(got.angle_two));
        if (got.angle_three !== want.angle_three)
            report_field("angle_three", int'(want.angle_three), int'(got.angle_three));
        if (got.magnet_on !== want.magnet_on)
            report_field("magnet_on", int'(want.magnet_on), int'(got.magnet_on));
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
            if (push && !full) predict_angles(sample_in);
            if (pop && !empty) check_angles(angles_out);
        end
    end

    // Result side: random stalls, or a long hold-off while one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("joystick_tilt_servo_smoother_tb: errors");
        $finish;
    end

    // Offer one item, with random idle cycles ahead of it, until it is taken.
    task automatic send_sample(input t_in_item s);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        sample_in <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Stop sending and let every expected result come out.
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_angles.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[8:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_sample(int jx, int jy, int ax, int ay, int az,
                                             int c, int z);
        t_in_item s;
        s.joy_x = 8'(jx);
        s.joy_y = 8'(jy);
        s.accel_x = 10'(ax);
        s.accel_y = 10'(ay);
        s.accel_z = 10'(az);
        s.button_c = c[0];
        s.button_z = z[0];
        return s;
    endfunction

    // Stick reading that often lands near the centre to exercise the deadband.
    function automatic int stick_value(longint ctr);
        int v;
        if ($urandom_range(9) < 3) begin
            v = int'(ctr) + int'($urandom_range(40)) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end else begin
            v = $urandom_range(255);
        end
        return v;
    endfunction

    function automatic int accel_value();
        int pick;
        pick = $urandom_range(19);
        if (pick < 2) return 0;
        if (pick < 5) return $urandom_range(15);
        return $urandom_range(1023);
    endfunction

    function automatic t_in_item random_sample();
        t_in_item s;
        s = make_sample(stick_value(ctr_x), stick_value(ctr_y), accel_value(),
                        accel_value(), accel_value(), $urandom_range(1),
                        $urandom_range(1));
        if ($urandom_range(19) == 0) begin
            s.accel_y = '0;
            s.accel_z = '0;
        end
        return s;
    endfunction

    // Reset values: deadband edges, stick extremes and the pitch corner cases.
    task automatic test_default_settings();
        send_idle_pct = 0;
        recv_stall_pct = 20;
        send_sample(make_sample(128, 128, 0, 0, 0, 0, 1));
        send_sample(make_sample(137, 119, 1023, 1023, 1023, 0, 1));
        send_sample(make_sample(138, 118, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 255, 512, 512, 512, 0, 0));
        send_sample(make_sample(255, 0, 1023, 0, 1023, 0, 1));
        // Level sample: no forward component, pitch is zero.
        send_sample(make_sample(255, 255, 0, 512, 512, 1, 0));
        // Pointing straight down: no vertical component.
        send_sample(make_sample(0, 0, 700, 0, 0, 1, 1));
        send_sample(make_sample(17, 200, 1023, 1023, 1023, 1, 0));
        send_sample(make_sample(90, 40, 1, 1023, 1023, 1, 1));
        send_sample(make_sample(3, 250, 1023, 0, 1, 1, 0));
        send_sample(make_sample(128, 128, 0, 0, 0, 1, 1));
    endtask

    // Register extremes, zero deadband, zero weight and weight above one.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_CENTER_X, 0);
        write_reg(CFG_CENTER_Y, 255);
        write_reg(CFG_DEADBAND, 0);
        write_reg(CFG_WEIGHT, 256);
        send_sample(make_sample(0, 255, 0, 0, 0, 0, 1));
        send_sample(make_sample(255, 0, 1023, 1023, 1023, 0, 0));
        send_sample(make_sample(0, 0, 512, 300, 0, 1, 1));
        wait_idle();
        write_reg(CFG_CENTER_X, 255);
        write_reg(CFG_CENTER_Y, 0);
        write_reg(CFG_DEADBAND, 255);
        write_reg(CFG_WEIGHT, 1);
        send_sample(make_sample(1, 254, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 255, 0, 0, 0, 0, 1));
        send_sample(make_sample(77, 66, 1023, 0, 0, 1, 0));
        wait_idle();
        // Zero weight freezes every filter.
        write_reg(CFG_WEIGHT, 0);
        send_sample(make_sample(0, 255, 0, 0, 0, 0, 1));
        send_sample(make_sample(0, 0, 300, 400, 500, 1, 0));
        wait_idle();
        write_reg(CFG_WEIGHT, 511);
        send_sample(make_sample(200, 10, 0, 0, 0, 0, 1));
        send_sample(make_sample(5, 5, 1023, 1, 1, 1, 1));
        send_sample(make_sample(100, 150, 0, 0, 0, 0, 0));
    endtask

    task automatic load_random_settings();
        wait_idle();
        write_reg(CFG_CENTER_X, $urandom_range(255));
        write_reg(CFG_CENTER_Y, $urandom_range(255));
        write_reg(CFG_DEADBAND,
                  ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(30));
        write_reg(CFG_WEIGHT,
                  ($urandom_range(4) == 0) ? $urandom_range(511, 257)
                                           : $urandom_range(256, 1));
    endtask

    // Random samples under two random settings with the given idle pattern.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        int seg;
        int n;
        for (seg = 0; seg < 2; seg++) begin
            load_random_settings();
            send_idle_pct = send_pct;
            recv_stall_pct = recv_pct;
            for (n = 0; n < count / 2; n++) begin
                send_sample(random_sample());
            end
        end
    endtask

    // Hold the result side off long enough that the block stops taking items.
    task automatic test_full_stall();
        int n;
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        for (n = 0; n < 40; n++) begin
            send_sample(random_sample());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_settings();
        test_register_extremes();
        test_random_traffic(16, 83, 540);
        test_random_traffic(83, 16, 540);
        test_random_traffic(0, 0, 540);
        test_full_stall();
        wait_idle();
        if (errors == 0) begin
            $display("joystick_tilt_servo_smoother_tb: clean");
        end else begin
            $display("joystick_tilt_servo_smoother_tb: errors");
        end
        $finish;
    end

endmodule
